// ===== rtl/ffpa_pkg.sv =====
// Package with the request/result types and codes of the first-fit partition allocator.
package ffpa_pkg;

  typedef struct packed {
    logic        op;
    logic [16:0] alloc_size;
    logic [5:0]  handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_address;
    logic [5:0]  assigned_handle;
    logic [1:0]  merge_kind;
  } rsp_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ARG  = 3'd1;
  localparam logic [2:0] ST_NO_FREE  = 3'd2;
  localparam logic [2:0] ST_NO_FIT   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] MK_NEW  = 2'd0;
  localparam logic [1:0] MK_PREV = 2'd1;
  localparam logic [1:0] MK_NEXT = 2'd2;
  localparam logic [1:0] MK_BOTH = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,      // issue read of free entry idx
    S_A_CHK,     // compare entry length with size
    S_A_UPD,     // shrink or start removal
    S_U_RD,      // read used entry handle
    S_U_LAT,
    S_R_RD,      // scan free table for a neighbor
    S_R_CHK,
    S_R_NXRD,    // read entry idx+1 for a double merge
    S_R_NXCHK,
    S_R_IRD,     // search insert position
    S_R_ICHK,
    S_FSH_RD,    // free table shift down (removal)
    S_FSH_WR,
    S_FSU_RD,    // free table shift up (insertion)
    S_FSU_WR,
    S_USH_RD,    // used table shift down
    S_USH_WR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/ffpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_partition_allocator_core.sv =====
// Top level of the first-fit partition allocator: sequencer, tables and shared adder.
//
// Usage. A request (op, alloc_size, handle) is taken at a rising edge where
// start is high and busy is low. busy then stays high while the sequencer
// walks the tables. Exactly one result per request appears on rsp for one
// cycle, marked by done; the receiver cannot hold it off. The next request
// can be taken in the cycle after done.
//
// Sequence. Every step touches one table entry through the registered read
// port of a RAM. A rejected request gives done in the cycle after it is
// taken. An allocate scans the free table up to the first fit and, on an
// exact fit, shifts the rest of it down. A release reads its used entry,
// scans the free table for a neighbor (or for the insert slot), shifts the
// free table up or down where needed, then shifts later used entries down;
// with a full free table and no neighbor it ends with ST_FULL instead. A
// release into an empty free table skips the scan and makes the block the
// only partition.
// A shared adder does the fit, neighbor-end and double-merge sums; the rest use own adders.
//
// Reset. rst clears the used count, sets the free count to one, makes the whole
// memory one free partition starting at 0 and holds that entry in a register flag
// until first written, so no clearing pass is needed; ready right after reset.
module first_fit_partition_allocator_core
  import ffpa_pkg::*;
#(
  parameter int MEMORY_UNITS = 65536,
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int FAW = $clog2(FREE_ENTRIES);
  localparam int UAW = $clog2(USED_ENTRIES);
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int HCW = (UCW > 6) ? UCW : 6;
  localparam logic [16:0] MEM_UNITS = 17'(MEMORY_UNITS);

  state_t state, state_next;

  req_t        r;
  logic [FCW-1:0] free_count;
  logic [UCW-1:0] used_count;
  logic        init0;         // free entry 0 still holds its reset value
  logic [FCW-1:0] idx;
  logic [FCW-1:0] lim;
  logic [UAW-1:0] uidx;
  logic [15:0] ustart;
  logic [16:0] ulen;
  logic [15:0] cur_s;
  logic [16:0] cur_l;
  logic [1:0]  kind;
  logic [2:0]  st;
  logic [15:0] addr_o;
  logic [5:0]  hnd_o;

  // RAM ports
  logic           f_we, u_we;
  logic [FAW-1:0] f_wa, f_ra;
  logic [UAW-1:0] u_wa, u_ra;
  logic [32:0]    f_wd, f_rd_raw, f_rd;
  logic [32:0]    u_wd, u_rd;
  logic           f_rd0;

  ffpa_ram #(.WIDTH(33), .DEPTH(FREE_ENTRIES)) u_free (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd_raw));
  ffpa_ram #(.WIDTH(33), .DEPTH(USED_ENTRIES)) u_used (
    .clk, .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));

  // Entry 0 reads as the reset partition until it is first written.
  always_ff @(posedge clk) begin
    f_rd0 <= (f_ra == '0) && init0;
  end
  assign f_rd = f_rd0 ? {16'd0, MEM_UNITS} : f_rd_raw;

  wire [15:0] rd_s = f_rd[32:17];
  wire [16:0] rd_l = f_rd[16:0];

  // Shared adder for the length and end-of-partition sums.
  logic [16:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  wire [16:0] uend = {1'b0, ustart} + ulen;

  always_comb begin
    add_a = 17'({1'b0, rd_s});
    add_b = rd_l;
    case (state)
      S_A_UPD: begin add_a = cur_l; add_b = ~r.alloc_size + 17'd1; end
      S_R_CHK: begin add_a = {1'b0, rd_s}; add_b = rd_l; end
      S_R_NXCHK: begin add_a = cur_l; add_b = rd_l; end
      default: ;
    endcase
  end

  wire [FCW:0] idx_p1 = {1'b0, idx} + 1'b1;
  wire [UCW-1:0] uidx_p1 = UCW'(uidx) + UCW'(1);
  wire bad_handle = (HCW'(req.handle) >= HCW'(used_count));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) begin
        if (req.op == OP_ALLOC) begin
          if (req.alloc_size == '0 || req.alloc_size > MEM_UNITS) state_next = S_DONE;
          else if (free_count == '0) state_next = S_DONE;
          else state_next = S_A_RD;
        end else begin
          if (bad_handle) state_next = S_DONE;
          else state_next = S_U_RD;
        end
      end
      S_A_RD:   state_next = S_A_CHK;
      S_A_CHK:  if (rd_l >= r.alloc_size) state_next =
                  (used_count >= UCW'(USED_ENTRIES)) ? S_DONE : S_A_UPD;
                else if (idx_p1[FCW-1:0] == free_count) state_next = S_DONE;
                else state_next = S_A_RD;
      S_A_UPD:  state_next = (cur_l == r.alloc_size) ? S_FSH_RD : S_DONE;
      S_U_RD:   state_next = S_U_LAT;
      S_U_LAT:  state_next = (free_count == '0) ? S_FSU_RD : S_R_RD;
      S_R_RD:   state_next = S_R_CHK;
      S_R_CHK: begin
        if (add_y == {1'b0, ustart}) begin
          state_next = (idx_p1[FCW-1:0] < free_count && idx_p1[FCW] == 1'b0) ?
                       S_R_NXRD : S_USH_RD;
        end else if ({1'b0, rd_s} == uend) state_next = S_USH_RD;
        else if (idx_p1[FCW-1:0] == free_count) state_next =
          (free_count >= FCW'(FREE_ENTRIES)) ? S_DONE : S_R_IRD;
        else state_next = S_R_RD;
      end
      S_R_NXRD:  state_next = S_R_NXCHK;
      S_R_NXCHK: state_next = ({1'b0, rd_s} == uend) ? S_FSH_RD : S_USH_RD;
      S_R_IRD:   state_next = S_R_ICHK;
      S_R_ICHK:  if (rd_s > ustart || idx_p1[FCW-1:0] == free_count) state_next = S_FSU_RD;
                 else state_next = S_R_IRD;
      S_FSH_RD:  state_next = (idx_p1[FCW-1:0] >= free_count) ?
                   ((r.op == OP_RELEASE) ? S_USH_RD : S_DONE) : S_FSH_WR;
      S_FSH_WR:  state_next = S_FSH_RD;
      S_FSU_RD:  state_next = (idx == lim) ? S_USH_RD : S_FSU_WR;
      S_FSU_WR:  state_next = S_FSU_RD;
      S_USH_RD:  state_next = (uidx_p1 >= used_count) ? S_DONE : S_USH_WR;
      S_USH_WR:  state_next = S_USH_RD;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    f_we = 1'b0; f_wa = idx[FAW-1:0]; f_wd = {cur_s, cur_l}; f_ra = idx[FAW-1:0];
    u_we = 1'b0; u_wa = used_count[UAW-1:0]; u_wd = '0; u_ra = uidx;
    case (state)
      S_A_UPD: begin
        u_we = 1'b1; u_wd = {cur_s, r.alloc_size};
        if (cur_l != r.alloc_size) begin
          f_we = 1'b1; f_wd = {cur_s + r.alloc_size[15:0], add_y};
        end
      end
      S_R_CHK: begin
        if (add_y == {1'b0, ustart}) begin
          f_we = 1'b1; f_wd = {rd_s, rd_l + ulen};
        end else if ({1'b0, rd_s} == uend) begin
          f_we = 1'b1; f_wd = {ustart, rd_l + ulen};
        end
      end
      S_R_NXRD: f_ra = idx_p1[FAW-1:0];
      S_R_NXCHK: if ({1'b0, rd_s} == uend) begin
        f_we = 1'b1; f_wd = {cur_s, add_y};
      end
      S_FSH_RD: f_ra = idx_p1[FAW-1:0];
      S_FSH_WR: begin f_we = 1'b1; f_wd = f_rd; end
      S_FSU_RD: begin
        f_ra = FAW'(idx - 1'b1);
        if (idx == lim) begin f_we = 1'b1; f_wd = {ustart, ulen}; end
      end
      S_FSU_WR: begin f_we = 1'b1; f_wd = f_rd; end
      S_USH_RD: u_ra = UAW'(uidx_p1);
      S_USH_WR: begin u_we = 1'b1; u_wa = uidx; u_wd = u_rd; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      free_count <= FCW'(1);
      used_count <= '0;
      init0 <= 1'b1;
    end else begin
      state <= state_next;
      if (f_we && f_wa == '0) init0 <= 1'b0;
      case (state)
        S_A_UPD: begin
          used_count <= used_count + 1'b1;
        end
        S_FSH_RD: if (idx_p1[FCW-1:0] >= free_count) free_count <= free_count - 1'b1;
        S_FSU_RD: if (idx == lim) free_count <= free_count + 1'b1;
        S_USH_RD: if (uidx_p1 >= used_count)
                    used_count <= used_count - 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (start) begin
        r <= req; idx <= '0; uidx <= UAW'(req.handle); kind <= MK_NEW;
        addr_o <= '0; hnd_o <= '0;
        if (req.op == OP_ALLOC) begin
          st <= (req.alloc_size == '0 || req.alloc_size > MEM_UNITS) ? ST_BAD_ARG :
                (free_count == '0) ? ST_NO_FREE : ST_OK;
        end else begin
          st <= bad_handle ? ST_BAD_ARG : ST_OK;
        end
      end
      S_A_CHK: if (rd_l >= r.alloc_size) begin
        cur_s <= rd_s; cur_l <= rd_l;
        if (used_count >= UCW'(USED_ENTRIES)) st <= ST_FULL;
        else begin addr_o <= rd_s; hnd_o <= 6'(used_count); end
      end else if (idx_p1[FCW-1:0] == free_count) st <= ST_NO_FIT;
      else idx <= idx_p1[FCW-1:0];
      S_U_LAT: begin
        ustart <= u_rd[32:17]; ulen <= u_rd[16:0]; addr_o <= u_rd[32:17];
        // An empty free table takes the block as its only partition.
        lim <= '0;
      end
      S_R_CHK: begin
        cur_s <= rd_s; cur_l <= rd_l + ulen;
        if (add_y == {1'b0, ustart}) kind <= MK_PREV;
        else if ({1'b0, rd_s} == uend) kind <= MK_NEXT;
        else if (idx_p1[FCW-1:0] == free_count) begin
          idx <= '0;
          if (free_count >= FCW'(FREE_ENTRIES)) begin
            st <= ST_FULL; addr_o <= '0;
          end
        end else idx <= idx_p1[FCW-1:0];
      end
      S_R_NXCHK: if ({1'b0, rd_s} == uend) begin
        kind <= MK_BOTH; idx <= idx_p1[FCW-1:0];
      end
      S_R_ICHK: begin
        if (rd_s > ustart) begin lim <= idx; idx <= free_count; end
        else if (idx_p1[FCW-1:0] == free_count) begin
          lim <= free_count; idx <= free_count;
        end else idx <= idx_p1[FCW-1:0];
      end
      S_FSH_WR: idx <= idx_p1[FCW-1:0];
      S_FSU_WR: idx <= idx - 1'b1;
      S_USH_WR: uidx <= UAW'(uidx_p1);
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  always_comb begin
    rsp = '0;
    rsp.status = st;
    if (st == ST_OK) begin
      rsp.start_address = addr_o;
      rsp.assigned_handle = (r.op == OP_ALLOC) ? hnd_o : '0;
      rsp.merge_kind = (r.op == OP_RELEASE) ? kind : MK_NEW;
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (free_count <= FCW'(FREE_ENTRIES)) && (used_count <= UCW'(USED_ENTRIES)))
    else $error("table count out of range");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("not idle after result");

endmodule
